// ----- design/double_ended_queue_with_search_macros.svh -----
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// Next-cycle implication, checked outside reset.
`define DQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

// ----- design/dqs_pkg.sv -----
// Shared types, constants and ring arithmetic for the deque.
package dqs_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		MD_PUSH_FRONT,
		MD_PUSH_BACK,
		MD_POP_FRONT,
		MD_POP_BACK,
		MD_SEARCH,
		MD_COUNT
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL,
		ST_NOTFOUND
	} status_t;

	// (base + off) mod CAPACITY, both operands below CAPACITY
	function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] base,
			logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(CAPACITY)) begin
			s = s - (IDX_W+1)'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

	// step one slot toward the front, wrapping
	function automatic logic [IDX_W-1:0] ring_dec(logic [IDX_W-1:0] base);
		logic [IDX_W-1:0] r;
		if (base == '0) begin
			r = IDX_W'(CAPACITY - 1);
		end else begin
			r = base - IDX_W'(1);
		end
		return r;
	endfunction

	// fit a count into a 5-bit result field
	function automatic logic [4:0] fit5(logic [CNT_W-1:0] v);
		logic [CNT_W+4:0] w;
		w = {5'b0, v};
		return w[4:0];
	endfunction

endpackage

// ----- design/dqs_req_if.sv -----
// Request channel: mode and value.
interface dqs_req_if
	import dqs_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] value;

	modport source(output valid, mode, value, input ready);
	modport sink(input valid, mode, value, output ready);
endinterface

// ----- design/dqs_rsp_if.sv -----
// Response channel: status, popped value, position, entry count.
interface dqs_rsp_if
	import dqs_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] popped_value;
	logic [4:0]         position;
	logic [4:0]         entry_count;

	modport source(output valid, status, popped_value, position, entry_count, input ready);
	modport sink(input valid, status, popped_value, position, entry_count, output ready);
endinterface

// ----- design/double_ended_queue_with_search.sv -----
// Top level of the bounded deque with linear search, ring buffer in one RAM.
//
//  channel | dir | payload                                      | handshake
//  --------+-----+----------------------------------------------+------------
//  req     | in  | mode[2:0], value[31:0]                       | valid/ready
//  rsp     | out | status[1:0], popped_value[31:0], position[4:0],| valid/ready
//          |     | entry_count[4:0]                             |
//
// Push, pop, count and any empty/full case go from idle straight to the output state.
// A search first scans k entries (1..count), comparing one per cycle, then moves to the output state.
// Reset clears front index, count and control; RAM contents are left as is,
// and only held entries are ever read, so no clearing pass is needed.
// A finished result sits in the rsp register; the next request is taken while
// it waits. A new result waits in its final state until the register is free.
`include "double_ended_queue_with_search_macros.svh"

module double_ended_queue_with_search
	import dqs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	dqs_req_if.sink   req,
	dqs_rsp_if.source rsp
);
	typedef enum logic [1:0] {
		S_IDLE,  // ready for a request
		S_SCAN,  // compare one entry per cycle
		S_OUT    // move result into the rsp register
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   front_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   chk_q;      // offset of the entry on rd_data during scan
	logic signed [31:0] key_q;
	status_t            res_status_q;
	logic [CNT_W-1:0]   res_pos_q;
	logic               res_pop_q;  // popped value comes from rd_data

	logic               out_valid_q;
	status_t            out_status_q;
	logic signed [31:0] out_popped_q;
	logic [4:0]         out_pos_q;
	logic [4:0]         out_count_q;

	// RAM ports
	logic              we, re;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [DATA_W-1:0] wdata, rd_data;

	logic              accept, full, empty, hit, last;
	logic [IDX_W-1:0]  chk_next;

	assign accept   = req.valid && req.ready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign hit      = (rd_data == DATA_W'(key_q));
	assign chk_next = chk_q + IDX_W'(1);
	assign last     = ((CNT_W'(chk_q) + CNT_W'(1)) == count_q);

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.popped_value = out_popped_q;
	assign rsp.position     = out_pos_q;
	assign rsp.entry_count  = out_count_q;

	// memory access decode
	always_comb begin
		we    = 1'b0;
		waddr = front_q;
		wdata = DATA_W'(req.value);
		re    = 1'b0;
		raddr = front_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.mode)
						MD_PUSH_FRONT: begin
							we    = !full;
							waddr = ring_dec(front_q);
						end
						MD_PUSH_BACK: begin
							we    = !full;
							waddr = ring_add(front_q, IDX_W'(count_q));
						end
						MD_POP_FRONT, MD_SEARCH: begin
							re    = !empty;
							raddr = front_q;
						end
						MD_POP_BACK: begin
							re    = !empty;
							raddr = ring_add(front_q, IDX_W'(count_q - CNT_W'(1)));
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				// prefetch the next entry while comparing this one
				if (!hit && !last) begin
					re    = 1'b1;
					raddr = ring_add(front_q, chk_next);
				end
			end
			default: begin
			end
		endcase
	end

	dqs_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			front_q      <= '0;
			count_q      <= '0;
			chk_q        <= '0;
			res_status_q <= ST_OK;
			res_pos_q    <= '0;
			res_pop_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_popped_q <= '0;
			out_pos_q    <= '0;
			out_count_q  <= '0;
			key_q        <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_pos_q    <= '0;
						res_pop_q    <= 1'b0;
						state_q      <= S_OUT;
						unique case (req.mode)
							MD_PUSH_FRONT: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									front_q <= ring_dec(front_q);
									count_q <= count_q + CNT_W'(1);
								end
							end
							MD_PUSH_BACK: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							MD_POP_FRONT: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									res_pop_q <= 1'b1;
									front_q   <= ring_add(front_q, IDX_W'(1));
									count_q   <= count_q - CNT_W'(1);
								end
							end
							MD_POP_BACK: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									res_pop_q <= 1'b1;
									count_q   <= count_q - CNT_W'(1);
								end
							end
							MD_SEARCH: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									key_q   <= req.value;
									chk_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								// count, and unused modes
							end
						endcase
					end
				end
				S_SCAN: begin
					priority if (hit) begin
						res_status_q <= ST_OK;
						res_pos_q    <= CNT_W'(chk_q) + CNT_W'(1);
						state_q      <= S_OUT;
					end else if (last) begin
						res_status_q <= ST_NOTFOUND;
						state_q      <= S_OUT;
					end else begin
						chk_q <= chk_next;
					end
				end
				S_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_popped_q <= res_pop_q ? $signed(rd_data) : '0;
						out_pos_q    <= fit5(res_pos_q);
						out_count_q  <= fit5(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DQS_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`DQS_ASSERT_IMP(a_no_rw_overlap, clk, arst_n, we, !re)
	`DQS_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == S_SCAN, CNT_W'(chk_q) < count_q)
	`DQS_ASSERT_NXT(a_pop_dec, clk, arst_n, accept && !empty && (req.mode == MD_POP_FRONT || req.mode == MD_POP_BACK), count_q == $past(count_q) - CNT_W'(1))
endmodule

// ----- design/dqs_ram.sv -----
// Generic one-write one-read RAM with registered read data.
module dqs_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- bench/tb_double_ended_queue_with_search.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the bounded deque with search, run against an in-bench ring model.
module tb_double_ended_queue_with_search
	import dqs_pkg::*;
;

	// Modes six and seven are not in mode_t; the block treats them as a count.
	localparam logic [2:0] MD_SPARE_6 = 3'd6;
	localparam logic [2:0] MD_SPARE_7 = 3'd7;

	// Receiver hold-off used to back the block up into its request port.
	localparam int LONG_HOLD_CYCLES = 300;
	// Quiet cycles after the last reply.
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		status_t            status;
		logic signed [31:0] popped_value;
		logic [4:0]         position;
		logic [4:0]         entry_count;
	} deque_reply_t;

	logic clk;
	logic arst_n;

	dqs_req_if req_ch();
	dqs_rsp_if rsp_ch();

	double_ended_queue_with_search u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow ring: same layout as the block, front slot plus held count.
	logic signed [31:0] shadow_slot [CAPACITY];
	int                 shadow_front;
	int                 shadow_held;

	// Replies owed by the block, oldest first.
	deque_reply_t replies_due [$];

	int fail_count;
	bit src_idle_on;
	bit sink_idle_on;
	bit long_hold_req;

	// 12 ns clock, low half first so the first rising edge lands at 6 ns.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Applies one request to the shadow ring and returns the reply it owes.
	function automatic deque_reply_t apply_deque_op(input logic [2:0] md,
			input logic signed [31:0] val);
		deque_reply_t r;
		int           k;
		r.status       = ST_OK;
		r.popped_value = '0;
		r.position     = '0;
		case (md)
			MD_PUSH_FRONT: begin
				if (shadow_held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
					shadow_slot[shadow_front] = val;
					shadow_held++;
				end
			end
			MD_PUSH_BACK: begin
				if (shadow_held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_slot[(shadow_front + shadow_held) % CAPACITY] = val;
					shadow_held++;
				end
			end
			MD_POP_FRONT: begin
				if (shadow_held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_value = shadow_slot[shadow_front];
					shadow_front   = (shadow_front + 1) % CAPACITY;
					shadow_held--;
				end
			end
			MD_POP_BACK: begin
				if (shadow_held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_value = shadow_slot[(shadow_front + shadow_held - 1) % CAPACITY];
					shadow_held--;
				end
			end
			MD_SEARCH: begin
				if (shadow_held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// first match counted from the front wins
					r.status = ST_NOTFOUND;
					for (k = 0; k < shadow_held; k++) begin
						if (r.status == ST_NOTFOUND &&
								shadow_slot[(shadow_front + k) % CAPACITY] == val) begin
							r.status   = ST_OK;
							r.position = 5'(k + 1);
						end
					end
				end
			end
			default: begin
				// count and the spare modes leave the ring alone
			end
		endcase
		r.entry_count = 5'(shadow_held);
		return r;
	endfunction

	// Entry k places back from the front of the shadow ring.
	function automatic logic signed [31:0] held_value(input int k);
		return shadow_slot[(shadow_front + k) % CAPACITY];
	endfunction

	// Value mix: a tiny pool so duplicates and hits are common, the two
	// extremes, and full-width random words.
	function automatic logic signed [31:0] random_word();
		logic signed [31:0] w;
		case ($urandom_range(0, 7))
			0, 1:    w = int'($urandom_range(0, 6)) - 3;
			2:       w = 32'sh8000_0000;
			3:       w = 32'sh7FFF_FFFF;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// Offers one transaction and holds it until the block takes it. Valid
	// stays high into the next call unless an idle burst is drawn, so the
	// caller must not let time pass without lowering it.
	task automatic send_req(input logic [2:0] md, input logic signed [31:0] val);
		req_ch.valid <= 1'b1;
		req_ch.mode  <= md;
		req_ch.value <= val;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		// accepted at this edge: predict now, state order matches the block
		replies_due.push_back(apply_deque_op(md, val));
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// One random request; push_w sets the percentage of pushes, which steers
	// the fill level toward empty, middle or full.
	task automatic send_random_op(input int push_w);
		logic [2:0]         md;
		logic signed [31:0] val;
		val = random_word();
		if ($urandom_range(0, 99) < push_w) begin
			md = $urandom_range(0, 1) ? MD_PUSH_BACK : MD_PUSH_FRONT;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: md = MD_POP_FRONT;
				3, 4, 5: md = MD_POP_BACK;
				6, 7, 8: begin
					md = MD_SEARCH;
					// mostly look for something that is held, anywhere in the ring
					if (shadow_held > 0 && $urandom_range(0, 2) != 0) begin
						val = held_value($urandom_range(0, shadow_held - 1));
					end
				end
				default: begin
					case ($urandom_range(0, 2))
						0:       md = MD_COUNT;
						1:       md = MD_SPARE_6;
						default: md = MD_SPARE_7;
					endcase
				end
			endcase
		end
		send_req(md, val);
	endtask

	// Empty-queue cases, both extremes of value, every mode, hits and misses.
	task automatic test_directed_corners();
		send_req(MD_COUNT, 32'sd0);
		send_req(MD_POP_FRONT, 32'sh5A5A_5A5A);
		send_req(MD_POP_BACK, 32'shA5A5_A5A5);
		send_req(MD_SEARCH, 32'sd0);
		send_req(MD_PUSH_FRONT, 32'sh8000_0000);
		send_req(MD_PUSH_BACK, 32'sh7FFF_FFFF);
		send_req(MD_PUSH_FRONT, 32'sd0);
		send_req(MD_PUSH_BACK, -32'sd1);
		send_req(MD_SEARCH, 32'sh7FFF_FFFF);
		send_req(MD_SEARCH, -32'sd1);
		send_req(MD_SEARCH, 32'sd0);
		send_req(MD_SEARCH, 32'sd1);
		send_req(MD_SPARE_6, 32'sh1234_5678);
		send_req(MD_SPARE_7, -32'sd1);
		send_req(MD_COUNT, 32'sh7FFF_FFFF);
		send_req(MD_POP_FRONT, 32'sd0);
		send_req(MD_POP_BACK, 32'sd0);
		send_req(MD_POP_FRONT, 32'sd0);
		send_req(MD_POP_BACK, 32'sd0);
		send_req(MD_POP_FRONT, 32'sd0);
	endtask

	// Fill to capacity from both ends, push into a full ring, search the
	// first and last positions, then drain it past empty.
	task automatic test_fill_to_full();
		int i;
		for (i = 0; i < CAPACITY; i++) begin
			send_req((i % 2) ? MD_PUSH_BACK : MD_PUSH_FRONT, 32'sh1000_0000 + i);
		end
		send_req(MD_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_req(MD_PUSH_BACK, 32'sh8000_0000);
		send_req(MD_SEARCH, held_value(CAPACITY - 1));
		send_req(MD_SEARCH, held_value(0));
		send_req(MD_COUNT, 32'sd0);
		for (i = 0; i <= CAPACITY; i++) begin
			send_req((i % 2) ? MD_POP_BACK : MD_POP_FRONT, 32'sd0);
		end
	endtask

	// Receiver goes quiet for a long stretch while requests keep coming, so
	// the reply register and the request port both back up.
	task automatic test_backpressure();
		long_hold_req = 1'b1;
		repeat (40) send_random_op(60);
	endtask

	// Random traffic in episodes, each episode biased toward a fill level.
	task automatic test_random_mix(input int n_items, input bit idling);
		int done;
		int push_w;
		src_idle_on  = idling;
		sink_idle_on = idling;
		done = 0;
		while (done < n_items) begin
			case ($urandom_range(0, 2))
				0:       push_w = 20;
				1:       push_w = 50;
				default: push_w = 85;
			endcase
			repeat ($urandom_range(20, 60)) begin
				send_random_op(push_w);
				done++;
			end
		end
	endtask

	// Reply receiver: one nonblocking write per pass, each pass ends on an edge.
	initial begin
		int hold_count;
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				rsp_ch.ready <= 1'b0;
				for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++) begin
					@(posedge clk);
				end
				long_hold_req = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Each reply transaction is checked field by field against the oldest
	// prediction.
	always @(posedge clk) begin : reply_check
		deque_reply_t due;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (replies_due.size() == 0) begin
				$error("reply with no request outstanding");
				fail_count++;
			end else begin
				due = replies_due.pop_front();
				if (rsp_ch.status !== due.status) begin
					$error("status: expected %0d, actual %0d", due.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.popped_value !== due.popped_value) begin
					$error("popped_value: expected %0d, actual %0d",
						due.popped_value, rsp_ch.popped_value);
					fail_count++;
				end
				if (rsp_ch.position !== due.position) begin
					$error("position: expected %0d, actual %0d",
						due.position, rsp_ch.position);
					fail_count++;
				end
				if (rsp_ch.entry_count !== due.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						due.entry_count, rsp_ch.entry_count);
					fail_count++;
				end
			end
		end
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.mode   = MD_COUNT;
		req_ch.value  = '0;
		rsp_ch.ready  = 1'b0;
		fail_count    = 0;
		src_idle_on   = 1'b0;
		sink_idle_on  = 1'b0;
		long_hold_req = 1'b0;
		shadow_front  = 0;
		shadow_held   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		test_directed_corners();
		test_fill_to_full();
		test_backpressure();
		test_random_mix(1000, 1'b1);
		// closing stretch runs back to back on both sides
		test_random_mix(250, 1'b0);

		req_ch.valid <= 1'b0;
		while (replies_due.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray reply after the last one owed
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
